// ===== rtl/bgd_pkg.sv =====
// Shared types and codes for the button gesture detector.
// No dependencies; imported by every module of the block.
package bgd_pkg;

  localparam int STAMP_W = 48;
  localparam int CFG_W   = 32;
  localparam int MAX_EV  = 3;

  typedef enum logic [1:0] {
    MODE_EDGE  = 2'd0,
    MODE_TIMER = 2'd1,
    MODE_INIT  = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    EV_PRESS   = 3'd0,
    EV_LONG    = 3'd1,
    EV_RELEASE = 3'd2,
    EV_CLICK   = 3'd3,
    EV_DOUBLE  = 3'd4
  } ev_kind_t;

  typedef enum logic [1:0] {
    REG_DEBOUNCE   = 2'd0,
    REG_HOLD_LIMIT = 2'd1,
    REG_DC_WINDOW  = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [CFG_W-1:0] debounce;
    logic [CFG_W-1:0] hold_limit;
    logic [CFG_W-1:0] dc_window;
  } cfg_t;

  typedef struct packed {
    ev_kind_t           kind;
    logic [STAMP_W-1:0] ev_time;
    logic [STAMP_W-1:0] held;
    logic               last;
  } event_t;

  function automatic event_t make_event(ev_kind_t k, logic [STAMP_W-1:0] tm,
                                        logic [STAMP_W-1:0] hd);
    event_t e;
    e.kind    = k;
    e.ev_time = tm;
    e.held    = hd;
    e.last    = 1'b0;
    return e;
  endfunction

endpackage

// ===== rtl/bgd_eval.sv =====
// Gesture state registers and the single-pass decision logic for one item.
// Depends on bgd_pkg; produces up to three events per item.
module bgd_eval #(
  parameter int TIME_WIDTH = 48
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        go,
  input  bgd_pkg::mode_t              mode,
  input  logic                        lvl,
  input  logic [TIME_WIDTH-1:0]       t,
  input  bgd_pkg::cfg_t               cfg,
  output bgd_pkg::event_t             ev [bgd_pkg::MAX_EV],
  output logic [1:0]                  ev_count
);
  import bgd_pkg::*;

  localparam int TW = TIME_WIDTH;
  localparam int EW = ((TW > CFG_W) ? TW : CFG_W) + 1;
  localparam logic [TW-1:0] TMAX = '1;

  logic          initialised, initialised_next;
  logic          level_now, level_now_next;
  logic          long_sent, long_sent_next;
  logic [TW-1:0] edge_time, edge_time_next;
  logic          edge_valid, edge_valid_next;
  logic [TW-1:0] press_time, press_time_next;
  logic          press_valid, press_valid_next;
  logic [TW-1:0] click_time, click_time_next;
  logic          click_valid, click_valid_next;

  logic [TW-1:0] since_edge, held, since_click, due_time, long_held;
  logic [EW-1:0] due_sum;
  logic          bounce, press_ge, held_ge_long, dc_within, dc_expired, long_fired;
  logic [1:0]    n;

  always_comb begin
    since_edge   = t - edge_time;
    bounce       = edge_valid && ((t < edge_time) || (EW'(since_edge) < EW'(cfg.debounce)));
    press_ge     = press_valid && (t >= press_time);
    held         = press_ge ? (t - press_time) : '0;
    held_ge_long = EW'(held) >= EW'(cfg.hold_limit);
    since_click  = t - click_time;
    dc_within    = click_valid &&
                   ((t < click_time) || (EW'(since_click) <= EW'(cfg.dc_window)));
    dc_expired   = click_valid && (t >= click_time) &&
                   (EW'(since_click) >= EW'(cfg.dc_window));
    due_sum      = EW'(press_time) + EW'(cfg.hold_limit);
    due_time     = (due_sum > EW'(TMAX)) ? TMAX : due_sum[TW-1:0];
    long_held    = (EW'(cfg.hold_limit) > EW'(TMAX)) ? TMAX : TW'(cfg.hold_limit);

    initialised_next = initialised;
    level_now_next   = level_now;
    long_sent_next   = long_sent;
    edge_time_next   = edge_time;
    edge_valid_next  = edge_valid;
    press_time_next  = press_time;
    press_valid_next = press_valid;
    click_time_next  = click_time;
    click_valid_next = click_valid;
    long_fired       = 1'b0;
    n                = 2'd0;
    for (int i = 0; i < MAX_EV; i++) begin
      ev[i] = make_event(EV_PRESS, '0, '0);
    end

    case (mode)
      MODE_INIT: begin
        initialised_next = 1'b1;
        level_now_next   = lvl;
        long_sent_next   = 1'b0;
        edge_time_next   = t;
        edge_valid_next  = 1'b1;
        press_valid_next = 1'b0;
        click_valid_next = 1'b0;
      end
      MODE_EDGE: begin
        if (!initialised) begin
          initialised_next = 1'b1;
          level_now_next   = lvl;
          long_sent_next   = 1'b0;
          edge_time_next   = t;
          edge_valid_next  = 1'b1;
          press_valid_next = 1'b0;
          click_valid_next = 1'b0;
        end else if (lvl != level_now && !bounce) begin
          edge_time_next  = t;
          edge_valid_next = 1'b1;
          level_now_next  = lvl;
          if (lvl) begin
            press_time_next  = t;
            press_valid_next = 1'b1;
            long_sent_next   = 1'b0;
            ev[0] = make_event(EV_PRESS, STAMP_W'(t), '0);
            n     = 2'd1;
          end else begin
            if (press_valid && !long_sent && held_ge_long) begin
              long_fired = 1'b1;
              ev[n] = make_event(EV_LONG, STAMP_W'(due_time), STAMP_W'(long_held));
              n     = n + 2'd1;
            end
            ev[n] = make_event(EV_RELEASE, STAMP_W'(t), STAMP_W'(held));
            n     = n + 2'd1;
            if (press_valid && !long_sent && !long_fired) begin
              ev[n] = make_event(EV_CLICK, STAMP_W'(t), STAMP_W'(held));
              n     = n + 2'd1;
              if (dc_within) begin
                ev[n] = make_event(EV_DOUBLE, STAMP_W'(t), STAMP_W'(held));
                n     = n + 2'd1;
                click_valid_next = 1'b0;
              end else begin
                click_time_next  = t;
                click_valid_next = 1'b1;
              end
            end
            press_valid_next = 1'b0;
            long_sent_next   = 1'b0;
          end
        end
      end
      MODE_TIMER: begin
        if (level_now && press_ge && !long_sent && held_ge_long) begin
          long_sent_next = 1'b1;
          ev[0] = make_event(EV_LONG, STAMP_W'(due_time), STAMP_W'(long_held));
          n     = 2'd1;
        end
        if (dc_expired) begin
          click_valid_next = 1'b0;
        end
      end
      default: begin
      end
    endcase

    for (int i = 0; i < MAX_EV; i++) begin
      ev[i].last = (n == 2'(i + 1));
    end
    ev_count = n;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      initialised <= 1'b0;
      level_now   <= 1'b0;
      long_sent   <= 1'b0;
      edge_valid  <= 1'b0;
      press_valid <= 1'b0;
      click_valid <= 1'b0;
    end else if (go) begin
      initialised <= initialised_next;
      level_now   <= level_now_next;
      long_sent   <= long_sent_next;
      edge_valid  <= edge_valid_next;
      press_valid <= press_valid_next;
      click_valid <= click_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      edge_time  <= edge_time_next;
      press_time <= press_time_next;
      click_time <= click_time_next;
    end
  end

  a_long_needs_press: assert property (@(posedge clk) disable iff (rst)
    long_sent |-> press_valid) else $error("long press flag without a press");
  a_press_needs_level: assert property (@(posedge clk) disable iff (rst)
    press_valid |-> level_now) else $error("press recorded while released");
  a_init_arms: assert property (@(posedge clk) disable iff (rst)
    go && (mode == MODE_INIT) |=> initialised) else $error("initial level not recorded");

endmodule

// ===== rtl/bgd_evq.sv =====
// Three-slot result buffer: loads all events of one item, hands them out in order.
// Depends on bgd_pkg for the event type.
module bgd_evq (
  input  logic            clk,
  input  logic            rst,
  input  logic            load,
  input  bgd_pkg::event_t ev_in [bgd_pkg::MAX_EV],
  input  logic [1:0]      ev_count,
  input  logic            out_stall,
  output logic            out_valid,
  output bgd_pkg::event_t head,
  output logic            can_load
);
  import bgd_pkg::*;

  event_t     slots [MAX_EV];
  logic [1:0] count;
  logic       pop;

  assign out_valid = (count != 2'd0);
  assign pop       = out_valid && !out_stall;
  assign can_load  = (count == 2'd0) || ((count == 2'd1) && pop);
  assign head      = slots[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else if (load) begin
      count <= ev_count;
    end else if (pop) begin
      count <= count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      slots <= ev_in;
    end else if (pop) begin
      slots[0] <= slots[1];
      slots[1] <= slots[2];
    end
  end

  a_load_room: assert property (@(posedge clk) disable iff (rst)
    load |-> can_load) else $error("item loaded over pending events");
  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    load && (ev_count != 2'd0) |=> out_valid) else $error("loaded events not shown");
  a_last_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid && (count == 2'd1) |-> head.last) else $error("final event not marked last");

endmodule

// ===== rtl/button_gesture_detector.sv =====
// Top level of the button gesture detector: config registers, input register,
// decision stage and result buffer. Depends on bgd_pkg, bgd_eval, bgd_evq.
//
//  channel | handshake             | payload
//  --------+-----------------------+-------------------------------------------
//  in      | in_valid / in_stall   | mode, level_pressed, stamp
//  out     | out_valid / out_stall | event_kind, event_time, held_time, last_of_run
//  cfg     | cfg_write             | cfg_index, cfg_data
//
// An item is held in the input register and is evaluated in one pass as it leaves;
// its results are registered in the result buffer before the first one is shown.
// An item's results occupy the result buffer until the last is taken; the next item
// can load as that last result leaves, so the single output port sets the rate.
// in_stall rises while the input register holds an item and the buffer still
// has more than one result left or its last one is stalled.
// Synchronous reset clears gesture flags, the input register's valid flag and buffer
// count; config returns to 0 / 1000 / 400.
module button_gesture_detector #(
  parameter int TIME_WIDTH = 48
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   mode,
  input  logic                         level_pressed,
  input  logic [bgd_pkg::STAMP_W-1:0]  stamp,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [2:0]                   event_kind,
  output logic [bgd_pkg::STAMP_W-1:0]  event_time,
  output logic [bgd_pkg::STAMP_W-1:0]  held_time,
  output logic                         last_of_run,
  input  logic                         cfg_write,
  input  logic [1:0]                   cfg_index,
  input  logic [bgd_pkg::CFG_W-1:0]    cfg_data
);
  import bgd_pkg::*;

  cfg_t                   cfg;
  logic                   hold_valid;
  logic [1:0]             mode_q;
  logic                   lvl_q;
  logic [STAMP_W-1:0]     stamp_q;
  logic                   go, can_load, accept;
  event_t                 ev [MAX_EV];
  logic [1:0]             ev_count;
  event_t                 head;

  assign in_stall = hold_valid && !can_load;
  assign accept   = in_valid && !in_stall;
  assign go       = hold_valid && can_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce   <= CFG_W'(0);
      cfg.hold_limit <= CFG_W'(1000);
      cfg.dc_window  <= CFG_W'(400);
    end else if (cfg_write) begin
      case (reg_idx_t'(cfg_index))
        REG_DEBOUNCE:   cfg.debounce   <= cfg_data;
        REG_HOLD_LIMIT: cfg.hold_limit <= cfg_data;
        REG_DC_WINDOW:  cfg.dc_window  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (accept) begin
      hold_valid <= 1'b1;
    end else if (go) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mode_q  <= mode;
      lvl_q   <= level_pressed;
      stamp_q <= stamp;
    end
  end

  bgd_eval #(
    .TIME_WIDTH(TIME_WIDTH)
  ) u_eval (
    .clk      (clk),
    .rst      (rst),
    .go       (go),
    .mode     (mode_t'(mode_q)),
    .lvl      (lvl_q),
    .t        (TIME_WIDTH'(stamp_q)),
    .cfg      (cfg),
    .ev       (ev),
    .ev_count (ev_count)
  );

  bgd_evq u_evq (
    .clk       (clk),
    .rst       (rst),
    .load      (go),
    .ev_in     (ev),
    .ev_count  (ev_count),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .head      (head),
    .can_load  (can_load)
  );

  assign event_kind  = head.kind;
  assign event_time  = head.ev_time;
  assign held_time   = head.held;
  assign last_of_run = head.last;

endmodule

// ===== tb/tb_button_gesture_detector.sv =====
// Self-checking testbench for button_gesture_detector: directed gestures, then random
// press/release/timer sequences under several register settings and handshake pressure.
// Depends on bgd_pkg and the button_gesture_detector RTL only.
module tb_button_gesture_detector;
  import bgd_pkg::*;

  localparam int                 STALL_LIMIT = 1000;
  localparam int                 SETTLE      = 8;
  localparam int                 MAX_GAP     = 20;
  localparam logic [1:0]         MODE_UNUSED = 2'd3;
  localparam logic [STAMP_W-1:0] STAMP_MAX   = '1;
  localparam logic [STAMP_W-1:0] RESTART_AT  = 48'h4000_0000_0000;

  logic               clk = 1'b0;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic [1:0]         mode;
  logic               level_pressed;
  logic [STAMP_W-1:0] stamp;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [2:0]         event_kind;
  logic [STAMP_W-1:0] event_time;
  logic [STAMP_W-1:0] held_time;
  logic               last_of_run;
  logic               cfg_write;
  logic [1:0]         cfg_index;
  logic [CFG_W-1:0]   cfg_data;

  button_gesture_detector dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .mode(mode), .level_pressed(level_pressed), .stamp(stamp),
    .out_valid(out_valid), .out_stall(out_stall),
    .event_kind(event_kind), .event_time(event_time), .held_time(held_time),
    .last_of_run(last_of_run),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // gesture tracking state and register copies
  logic [CFG_W-1:0]   debounce_ticks = 32'd0;
  logic [CFG_W-1:0]   long_ticks     = 32'd1000;
  logic [CFG_W-1:0]   window_ticks   = 32'd400;
  logic               armed, level_down, long_done, edge_ok, press_ok, click_ok;
  logic [STAMP_W-1:0] last_edge_at, press_at, click_at;

  event_t             pending_events[$];
  int                 mismatches = 0;
  int                 quiet_cycles = 0;
  int                 in_idle_pct = 0;
  int                 out_stall_pct = 0;
  int                 items_sent = 0;
  logic               item_offered = 1'b0;
  logic [STAMP_W-1:0] now = '0;

  function automatic void restart_level(input logic lvl, input logic [STAMP_W-1:0] t);
    armed        = 1'b1;
    level_down   = lvl;
    long_done    = 1'b0;
    last_edge_at = t;
    edge_ok      = 1'b1;
    press_at     = '0;
    press_ok     = 1'b0;
    click_at     = '0;
    click_ok     = 1'b0;
  endfunction

  function automatic logic [STAMP_W-1:0] long_due_at();
    return (STAMP_W'(long_ticks) > STAMP_MAX - press_at) ? STAMP_MAX
                                                         : press_at + STAMP_W'(long_ticks);
  endfunction

  function automatic void predict_events(input logic [1:0] m, input logic lvl,
                                         input logic [STAMP_W-1:0] t);
    event_t             evs [MAX_EV];
    int                 n;
    logic [STAMP_W-1:0] hold_span;
    n = 0;
    case (m)
      MODE_INIT: restart_level(lvl, t);
      MODE_EDGE: begin
        if (!armed) begin
          restart_level(lvl, t);
        end else if (lvl != level_down &&
                     !(edge_ok && (t < last_edge_at ||
                                   t - last_edge_at < STAMP_W'(debounce_ticks)))) begin
          last_edge_at = t;
          edge_ok      = 1'b1;
          level_down   = lvl;
          if (lvl) begin
            press_at  = t;
            press_ok  = 1'b1;
            long_done = 1'b0;
            evs[n] = '{EV_PRESS, t, '0, 1'b0};
            n++;
          end else begin
            hold_span = (press_ok && t >= press_at) ? t - press_at : '0;
            if (press_ok && !long_done && hold_span >= STAMP_W'(long_ticks)) begin
              long_done = 1'b1;
              evs[n] = '{EV_LONG, long_due_at(), STAMP_W'(long_ticks), 1'b0};
              n++;
            end
            evs[n] = '{EV_RELEASE, t, hold_span, 1'b0};
            n++;
            if (press_ok && !long_done) begin
              evs[n] = '{EV_CLICK, t, hold_span, 1'b0};
              n++;
              if (click_ok && (t < click_at || t - click_at <= STAMP_W'(window_ticks))) begin
                evs[n] = '{EV_DOUBLE, t, hold_span, 1'b0};
                n++;
                click_ok = 1'b0;
                click_at = '0;
              end else begin
                click_at = t;
                click_ok = 1'b1;
              end
            end
            press_at  = '0;
            press_ok  = 1'b0;
            long_done = 1'b0;
          end
        end
      end
      MODE_TIMER: begin
        if (level_down && press_ok && !long_done && t >= press_at &&
            t - press_at >= STAMP_W'(long_ticks)) begin
          long_done = 1'b1;
          evs[n] = '{EV_LONG, long_due_at(), STAMP_W'(long_ticks), 1'b0};
          n++;
        end
        if (click_ok && t >= click_at && t - click_at >= STAMP_W'(window_ticks)) begin
          click_ok = 1'b0;
          click_at = '0;
        end
      end
      default: ;
    endcase
    for (int i = 0; i < n; i++) begin
      if (i == n - 1) evs[i].last = 1'b1;
      pending_events.insert(pending_events.size(), evs[i]);
    end
  endfunction

  task automatic send_item(input logic [1:0] m, input logic lvl,
                           input logic [STAMP_W-1:0] t);
    int gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < in_idle_pct) gap++;
    if (gap != 0) begin
      if (item_offered) in_valid <= 1'b0;
      item_offered = 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    mode          <= m;
    level_pressed <= lvl;
    stamp         <= t;
    item_offered  = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_events(m, lvl, t);
    items_sent++;
  endtask

  task automatic settle();
    if (item_offered) in_valid <= 1'b0;
    item_offered = 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_config(input logic [CFG_W-1:0] db, input logic [CFG_W-1:0] lp,
                            input logic [CFG_W-1:0] dc);
    cfg_write <= 1'b1;
    cfg_index <= REG_DEBOUNCE;
    cfg_data  <= db;
    @(posedge clk);
    cfg_index <= REG_HOLD_LIMIT;
    cfg_data  <= lp;
    @(posedge clk);
    cfg_index <= REG_DC_WINDOW;
    cfg_data  <= dc;
    @(posedge clk);
    cfg_write <= 1'b0;
    debounce_ticks = db;
    long_ticks     = lp;
    window_ticks   = dc;
  endtask

  task automatic set_idling(input int in_pct, input int out_pct);
    in_idle_pct   = in_pct;
    out_stall_pct = out_pct;
  endtask

  function automatic logic [STAMP_W-1:0] span_near(input logic [CFG_W-1:0] base);
    case ($urandom_range(5))
      0:       return '0;
      1:       return (base == 0) ? '0 : STAMP_W'(base) - 1;
      2:       return STAMP_W'(base);
      3:       return STAMP_W'(base) + 1;
      4:       return STAMP_W'($urandom_range(base));
      default: return STAMP_W'(base) + STAMP_W'($urandom_range(base));
    endcase
  endfunction

  task automatic random_gesture();
    logic [STAMP_W-1:0] t_press;
    logic [STAMP_W-1:0] t_rel;
    if (now > RESTART_AT) begin
      now = STAMP_W'($urandom_range(1000));
      send_item(MODE_INIT, 1'($urandom_range(1)), now);
    end
    now = now + span_near(window_ticks) + span_near(debounce_ticks);
    t_press = now;
    send_item(MODE_EDGE, 1'b1, t_press);
    if ($urandom_range(3) == 0) begin
      now = now + STAMP_W'($urandom_range(debounce_ticks));
      send_item(MODE_EDGE, 1'b0, now);
    end
    if ($urandom_range(2) == 0) begin
      t_rel = t_press + span_near(long_ticks);
      if (t_rel > now) now = t_rel;
      send_item(MODE_TIMER, 1'($urandom_range(1)), now);
    end
    t_rel = t_press + span_near(long_ticks);
    if (t_rel > now) now = t_rel;
    send_item(MODE_EDGE, 1'b0, now);
    if ($urandom_range(2) == 0) begin
      now = now + span_near(window_ticks);
      send_item(MODE_TIMER, 1'($urandom_range(1)), now);
    end
  endtask

  task automatic random_noise();
    logic [STAMP_W-1:0] t;
    case ($urandom_range(3))
      0:       t = now + STAMP_W'($urandom_range(64));
      1:       t = (now > 64) ? now - STAMP_W'($urandom_range(64)) : '0;
      2:       t = {16'($urandom), 32'($urandom)};
      default: t = now;
    endcase
    if (t > now) now = t;
    send_item(2'($urandom_range(3)), 1'($urandom_range(1)), t);
  endtask

  task automatic test_basic_gestures();
    send_item(MODE_TIMER,  1'b0, 48'd0);
    send_item(MODE_EDGE,   1'b1, 48'd10);
    send_item(MODE_TIMER,  1'b0, 48'd5000);
    send_item(MODE_EDGE,   1'b0, 48'd20);
    send_item(MODE_UNUSED, 1'b1, 48'd30);
    send_item(MODE_INIT,   1'b0, 48'd40);
    send_item(MODE_EDGE,   1'b0, 48'd50);
    send_item(MODE_EDGE,   1'b1, 48'd100);
    send_item(MODE_EDGE,   1'b0, 48'd150);
    send_item(MODE_EDGE,   1'b1, 48'd200);
    send_item(MODE_EDGE,   1'b0, 48'd300);
    send_item(MODE_EDGE,   1'b1, 48'd1000);
    send_item(MODE_TIMER,  1'b0, 48'd1999);
    send_item(MODE_TIMER,  1'b1, 48'd2000);
    send_item(MODE_EDGE,   1'b0, 48'd2100);
    send_item(MODE_EDGE,   1'b1, 48'd3000);
    send_item(MODE_EDGE,   1'b0, 48'd4500);
    send_item(MODE_EDGE,   1'b1, 48'd5000);
    send_item(MODE_EDGE,   1'b0, 48'd5050);
    send_item(MODE_TIMER,  1'b0, 48'd5450);
    send_item(MODE_EDGE,   1'b1, 48'd5500);
    send_item(MODE_EDGE,   1'b0, 48'd5550);
    send_item(MODE_EDGE,   1'b1, 48'd5400);
  endtask

  task automatic test_stamp_extremes();
    settle();
    set_config(32'd5, 32'd1000, 32'd400);
    send_item(MODE_INIT, 1'b0, STAMP_MAX - 10);
    send_item(MODE_EDGE, 1'b1, STAMP_MAX - 6);
    send_item(MODE_EDGE, 1'b1, STAMP_MAX - 5);
    send_item(MODE_EDGE, 1'b0, STAMP_MAX);
    now = STAMP_MAX;
  endtask

  task automatic test_random_gestures(input logic [CFG_W-1:0] db, input logic [CFG_W-1:0] lp,
                                      input logic [CFG_W-1:0] dc, input int count);
    int target;
    settle();
    set_config(db, lp, dc);
    target = items_sent + count;
    while (items_sent < target) begin
      if ($urandom_range(4) == 0) random_noise();
      else random_gesture();
    end
  endtask

  initial begin
    rst           = 1'b1;
    in_valid      = 1'b0;
    mode          = MODE_EDGE;
    level_pressed = 1'b0;
    stamp         = '0;
    cfg_write     = 1'b0;
    cfg_index     = REG_DEBOUNCE;
    cfg_data      = '0;
    restart_level(1'b0, '0);
    armed   = 1'b0;
    edge_ok = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    set_idling(13, 47);
    test_basic_gestures();
    test_stamp_extremes();
    test_random_gestures(32'd20, 32'd300, 32'd150, 55);
    set_idling(47, 13);
    test_random_gestures('1, '1, '1, 40);
    test_random_gestures(32'($urandom_range(100)), 32'($urandom_range(2000, 1)),
                         32'($urandom_range(800, 1)), 20);
    set_idling(0, 0);
    test_random_gestures(32'd0, 32'd1, 32'd1, 40);
    test_random_gestures(32'($urandom_range(100)), 32'($urandom_range(2000, 1)),
                         32'($urandom_range(800, 1)), 30);
    settle();
    if (mismatches == 0 && pending_events.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  always @(posedge clk) begin : result_check
    event_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_events.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected event: kind %0d time %0d held %0d last %0d",
                   event_kind, event_time, held_time, last_of_run);
        mismatches++;
      end else begin
        want = pending_events.pop_front();
        if (event_kind !== want.kind || event_time !== want.ev_time ||
            held_time !== want.held || last_of_run !== want.last) begin
          if (mismatches < 10) begin
            $display("event mismatch: expected kind %0d time %0d held %0d last %0d",
                     want.kind, want.ev_time, want.held, want.last);
            $display("                got kind %0d time %0d held %0d last %0d",
                     event_kind, event_time, held_time, last_of_run);
          end
          mismatches++;
        end
      end
    end
    out_stall <= ($urandom_range(99) < out_stall_pct);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

// ===== files.f =====
rtl/bgd_pkg.sv
rtl/bgd_eval.sv
rtl/bgd_evq.sv
rtl/button_gesture_detector.sv
tb/tb_button_gesture_detector.sv
